@@ src/fss_pkg.sv @@
// Package for the fuzzy subsequence scorer: sizes, command codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
package fss_pkg;
   localparam int PatternMaxDef = 32;
   localparam int TargetMaxDef  = 1024;
   localparam int ChW  = 8;
   localparam int PosW = 11;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_TARGET = 2'd2,
      MODE_END    = 2'd3
   } mode_type;

   // Command to each cell: step and restart are broadcast to every cell, load is per cell
   typedef struct packed {
      logic          load;    // append pattern character at this cell
      logic          step;    // take a target character
      logic          restart; // drop window contents
   } cell_ctl_type;

   // Fold A-Z to lower case
   function automatic logic [ChW-1:0] fold(input logic [ChW-1:0] c);
      logic [ChW-1:0] r;
      r = c;
      if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
      return r;
   endfunction

   // Judge state machine
   typedef enum logic [2:0] {
      ST_RUN, ST_DIV1, ST_DIV2, ST_SCORE, ST_OUT
   } judge_state_type;
endpackage

@@ src/fss_cell.sv @@
// One cell of the match row: holds a pattern character and a window character.
// Depends on fss_pkg.
`timescale 1ns / 1ps
module fss_cell
   import fss_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cell_ctl_type     ctl,
   input  logic [ChW-1:0]   ch,
   input  logic [ChW-1:0]   win_prev,
   output logic [ChW-1:0]   win_out,
   output logic [ChW-1:0]   pat_out
);
   logic [ChW-1:0] pat_ff, win_ff;

   // Load the pattern character when addressed
   always_ff @(posedge clock) begin
      if (ctl.load) pat_ff <= ch;
   end

   // Shift the window towards the oldest end
   always_ff @(posedge clock) begin
      if (reset || ctl.restart) win_ff <= '0;
      else if (ctl.step)        win_ff <= win_prev;
   end

   assign win_out = win_ff;
   assign pat_out = pat_ff;
endmodule

@@ src/fss_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on fss_pkg.
`timescale 1ns / 1ps
module fss_divider
   import fss_pkg::*;
#(
   parameter int W = 13
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         done,
   output logic [W-1:0] quo
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] q_ff, r_ff, d_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff, done_ff;
   logic [W:0] trial;

   assign trial = {r_ff, q_ff[W-1]} - {1'b0, d_ff};

   // Produce one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= num;
         r_ff <= '0;
         d_ff <= den;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            r_ff <= trial[W-1:0];
            q_ff <= {q_ff[W-2:0], 1'b1};
         end else begin
            r_ff <= {r_ff[W-2:0], q_ff[W-1]};
            q_ff <= {q_ff[W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

@@ src/fuzzy_subsequence_scorer.sv @@
// Top level of the fuzzy subsequence scorer: cell row, greedy tracker, judge.
// Depends on fss_pkg, fss_cell, fss_divider.
//
// Channel | Dir | Signals                    | Content
// req     | in  | req_tvalid/tready/tdata    | mode[1:0], ch[9:2]
// rsp     | out | rsp_tvalid/tready/tdata    | matched, score[12:1], exact_hit, overflow
//
// Pattern and target requests are taken back to back while the judge is idle.
// End of target runs three serial divisions by a shared one-bit-a-cycle divider, then
// scoring; no request is taken meanwhile. Result waits in an output register until taken.
// Synchronous active-high reset.
`timescale 1ns / 1ps
module fuzzy_subsequence_scorer
   import fss_pkg::*;
#(
   parameter int PATTERN_MAX = PatternMaxDef,
   parameter int TARGET_MAX  = TargetMaxDef
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // mode[1:0], ch[9:2], zeros
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // matched[0], score[12:1], exact_hit[13], overflow[14]
);
   localparam int LW = $clog2(PATTERN_MAX + 1);
   localparam int DW = 13;
   localparam logic [PosW-1:0] FirstNone = '1;

   mode_type       mode;
   logic [ChW-1:0] ch;
   logic           acc;
   assign mode = mode_type'(req_tdata[1:0]);
   assign ch   = fold(req_tdata[9:2]);
   assign acc  = req_tvalid && req_tready;

   judge_state_type st_ff, st_in;
   logic [LW-1:0]   plen_ff, seq_ff, run_ff, best_ff;
   logic [PosW-1:0] tpos_ff, first_ff, last_ff, subpos_ff;
   logic            subf_ff, ovf_ff;
   logic            rsp_v_ff;
   logic [15:0]     rsp_d_ff;

   // Cell row
   cell_ctl_type   ctl [PATTERN_MAX];
   logic [ChW-1:0] win [PATTERN_MAX];
   logic [ChW-1:0] pat [PATTERN_MAX];
   logic           restart;
   logic           do_step;
   assign do_step = acc && mode == MODE_TARGET && tpos_ff < PosW'(TARGET_MAX);
   assign restart = acc && mode != MODE_TARGET;

   genvar g;
   generate
      for (g = 0; g < PATTERN_MAX; g++) begin : g_cell
         logic [ChW-1:0] prev;
         if (g == PATTERN_MAX - 1) begin : g_last
            assign prev = ch;
         end else begin : g_mid
            assign prev = win[g+1];
         end
         assign ctl[g].load = acc && mode == MODE_APPEND && plen_ff == LW'(g);
         assign ctl[g].step = do_step;
         assign ctl[g].restart = restart;
         fss_cell u_cell (.clock, .reset, .ctl(ctl[g]), .ch, .win_prev(prev),
                          .win_out(win[g]), .pat_out(pat[g]));
      end
   endgenerate

   // Substring compare over the window after this character is shifted in
   logic sub_eq;
   always_comb begin
      sub_eq = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (LW'(i) < plen_ff) begin
            if (PATTERN_MAX - int'(plen_ff) + i == PATTERN_MAX - 1) begin
               if (ch != pat[i]) sub_eq = 1'b0;
            end else if (win[PATTERN_MAX - int'(plen_ff) + i + 1] != pat[i]) begin
               sub_eq = 1'b0;
            end
         end
      end
   end

   logic [ChW-1:0] seq_ch;
   assign seq_ch = pat[seq_ff[$clog2(PATTERN_MAX)-1:0]];

   // Target state
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         tpos_ff <= '0; subf_ff <= 1'b0; subpos_ff <= '0; seq_ff <= '0;
         run_ff <= '0; best_ff <= '0; first_ff <= FirstNone; last_ff <= '0;
      end else if (acc && mode == MODE_TARGET) begin
         if (!do_step) tpos_ff <= PosW'(TARGET_MAX + 1);
         else begin
            tpos_ff <= tpos_ff + 1'b1;
            if (!subf_ff && plen_ff != '0 && tpos_ff + 1'b1 >= PosW'(plen_ff) && sub_eq) begin
               subf_ff   <= 1'b1;
               subpos_ff <= tpos_ff + 1'b1 - PosW'(plen_ff);
            end
            if (seq_ff < plen_ff) begin
               if (seq_ch == ch) begin
                  if (first_ff == FirstNone) first_ff <= tpos_ff;
                  last_ff <= tpos_ff;
                  seq_ff  <= seq_ff + 1'b1;
                  run_ff  <= run_ff + 1'b1;
                  if (run_ff + 1'b1 > best_ff) best_ff <= run_ff + 1'b1;
               end else run_ff <= '0;
            end
         end
      end
   end

   // Pattern length and overflow flag
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= '0; ovf_ff <= 1'b0;
      end else if (acc && mode == MODE_CLEAR) begin
         plen_ff <= '0; ovf_ff <= 1'b0;
      end else if (acc && mode == MODE_APPEND) begin
         if (plen_ff < LW'(PATTERN_MAX)) plen_ff <= plen_ff + 1'b1;
         else ovf_ff <= 1'b1;
      end
   end

   // Judge snapshot so the row may restart
   logic [LW-1:0]   j_n, j_seq, j_best;
   logic [PosW-1:0] j_t, j_first, j_last, j_spos;
   logic            j_sub, j_ovf;
   logic [DW-1:0]   dens_ff, cov_ff;
   always_ff @(posedge clock) begin
      if (acc && mode == MODE_END) begin
         j_n <= plen_ff; j_seq <= seq_ff; j_best <= best_ff; j_t <= tpos_ff;
         j_first <= first_ff; j_last <= last_ff; j_spos <= subpos_ff; j_sub <= subf_ff;
         j_ovf <= ovf_ff || tpos_ff > PosW'(TARGET_MAX);
      end
   end

   // Shared divider: coverage, density, consecutive
   logic          dv_start, dv_done;
   logic [DW-1:0] dv_num, dv_den, dv_q;
   logic [PosW-1:0] span;
   assign span = j_last - j_first + 1'b1;
   fss_divider #(.W(DW)) u_div (.clock, .reset, .start(dv_start), .num(dv_num),
                               .den(dv_den), .done(dv_done), .quo(dv_q));

   always_comb begin
      dv_start = 1'b0;
      dv_num   = DW'(j_n) * DW'(100);
      dv_den   = (j_t == '0) ? DW'(1) : DW'(j_t);
      if (st_ff == ST_RUN) begin
         // Snapshot is loaded on this same edge, so take the live counts
         dv_start = acc && mode == MODE_END;
         dv_num   = DW'(plen_ff) * DW'(100);
         dv_den   = (tpos_ff == '0) ? DW'(1) : DW'(tpos_ff);
      end
      if (st_ff == ST_DIV1) begin
         dv_start = dv_done;
         dv_den   = (span == '0) ? DW'(1) : DW'(span);
      end
      if (st_ff == ST_DIV2) begin
         dv_start = dv_done;
         dv_num   = DW'(j_best) * DW'(30);
         dv_den   = (j_n == '0) ? DW'(1) : DW'(j_n);
      end
   end

   // Next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_RUN:   if (acc && mode == MODE_END) st_in = ST_DIV1;
         ST_DIV1:  if (dv_done) st_in = ST_DIV2;
         ST_DIV2:  if (dv_done) st_in = ST_SCORE;
         ST_SCORE: if (dv_done) st_in = ST_OUT;
         ST_OUT:   if (!rsp_v_ff) st_in = ST_RUN;
         default:  st_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_RUN;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_DIV1 && dv_done) cov_ff <= dv_q;
      if (st_ff == ST_DIV2 && dv_done) dens_ff <= dv_q;
   end

   // Score; the consecutive term is the quotient still held by the divider
   logic        m, ex;
   logic [11:0] sc;
   logic [DW-1:0] dens_s, cov_s, pos_s, sum;
   always_comb begin
      dens_s = dens_ff < DW'(100) ? dens_ff : DW'(100);
      cov_s  = cov_ff < DW'(50) ? {cov_ff[DW-2:0], 1'b0} : DW'(100);
      pos_s  = j_first < PosW'(50) ? DW'(50) - DW'(j_first) : '0;
      sum    = dens_s + dv_q + cov_s + pos_s;
      m = 1'b0; ex = 1'b0; sc = '0;
      if (j_ovf) begin
         m = 1'b0;
      end else if (j_n == '0) begin
         m = 1'b1;
      end else if (j_t == '0) begin
         m = 1'b0;
      end else if (j_sub) begin
         m = 1'b1; ex = 1'b1;
         sc = 12'(12'd1000 - 12'(j_spos) + 12'(cov_ff));
      end else if (j_n >= LW'(3) && j_seq == j_n && j_first != FirstNone
                   && j_last >= j_first && dens_ff >= DW'(20)
                   && !(cov_ff < DW'(15) && j_t > PosW'(20)) && sum >= DW'(80)) begin
         m = 1'b1; sc = sum[11:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (st_ff == ST_SCORE && dv_done) rsp_v_ff <= 1'b1;
      else if (rsp_tready) rsp_v_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (st_ff == ST_OUT && !rsp_v_ff) rsp_d_ff <= rsp_d_ff;
      if (st_in == ST_OUT && st_ff == ST_SCORE)
         rsp_d_ff <= {1'b0, j_ovf, ex, sc, m};
   end

   assign req_tready = st_ff == ST_RUN;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

`ifndef ASSERT_OFF
   a_no_req_in_judge: assert property (@(posedge clock) disable iff (reset)
      st_ff != ST_RUN |-> !req_tready) else $error("request taken while judging");
   a_rsp_after_score: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(st_ff) == ST_SCORE) else $error("stray response");
   a_ovf_nomatch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[14] |-> !rsp_tdata[0]) else $error("overflow with match");
`endif
endmodule
